// ===== design/usv_pkg.sv =====
// shared types and constants for the uv sphere vertex generator
package usv_pkg;

    localparam int ROW_W   = 8;
    localparam int DW      = 9;
    localparam int DIV_W   = 41;
    localparam int LANES   = 4;
    localparam int VAL_W   = 18;
    localparam int TDATA_W = 24;
    localparam int MAG_W   = 32;
    localparam int TH_W    = 31;
    localparam int TH2_W   = 32;
    localparam int INNER_W = 31;
    localparam int QDIV_W  = 30;
    localparam int STEPS   = 5;

    // lane order in the divider chain
    localparam int LANE_PU = 0;
    localparam int LANE_PV = 1;
    localparam int LANE_U  = 2;
    localparam int LANE_V  = 3;

    // stage counts: sine lane is fold, th, th2, three per series step, final product
    localparam int SINE_LAT = 3 + 3 * STEPS + 1;
    localparam int PIPE_LAT = DIV_W + SINE_LAT + 2;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] QUARTER     = 32'h4000_0000;

    localparam logic [6:0]  SERIES_DIV [STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [29:0] SERIES_RCP [STEPS] =
        '{30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882};

    typedef enum logic [2:0] {
        COMP_X  = 3'd0,
        COMP_Y  = 3'd1,
        COMP_Z  = 3'd2,
        COMP_NX = 3'd3,
        COMP_NY = 3'd4,
        COMP_NZ = 3'd5,
        COMP_U  = 3'd6,
        COMP_V  = 3'd7
    } comp_t;

    typedef enum logic [1:0] {
        REG_GRID_SIZE   = 2'd0,
        REG_EMIT_UV     = 2'd1,
        REG_EMIT_NORMAL = 2'd2
    } reg_idx_t;

    typedef logic [LANES-1:0][DW-1:0]    rem_vec_t;
    typedef logic [LANES-1:0][DIV_W-1:0] word_vec_t;

    typedef struct packed {
        logic [TH_W-1:0]    th;
        logic [TH2_W-1:0]   th2;
        logic [INNER_W-1:0] inner;
        logic               neg;
    } series_t;

endpackage

// ===== design/usv_div_cell.sv =====
// one restoring division step for all divider lanes
module usv_div_cell
(
    input  logic             clk,
    input  logic             en,
    input  logic [usv_pkg::DW-1:0] d,
    input  usv_pkg::rem_vec_t  rem_in,
    input  usv_pkg::word_vec_t word_in,
    output usv_pkg::rem_vec_t  rem_out,
    output usv_pkg::word_vec_t word_out
);
    import usv_pkg::*;

    rem_vec_t  rem_reg, rem_next;
    word_vec_t word_reg, word_next;

    always_comb
    begin
        logic [DW:0] trial;
        for (int i = 0; i < LANES; i++)
        begin
            trial = {rem_in[i], word_in[i][DIV_W-1]};
            if (trial >= {1'b0, d})
            begin
                rem_next[i]  = DW'(trial - {1'b0, d});
                word_next[i] = {word_in[i][DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = trial[DW-1:0];
                word_next[i] = {word_in[i][DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
        end
    end

    assign rem_out  = rem_reg;
    assign word_out = word_reg;

endmodule

// ===== design/usv_horner_cell.sv =====
// one step of the sine series: multiply, reciprocal divide, correct
module usv_horner_cell #(
    parameter int STEP = 0
)
(
    input  logic             clk,
    input  logic             en,
    input  usv_pkg::series_t s_in,
    output usv_pkg::series_t s_out
);
    import usv_pkg::*;

    series_t          a_reg, b_reg, c_reg;
    logic [31:0]      xa_reg, xb_reg;
    logic [QDIV_W-1:0] q0_reg;
    logic [62:0]      prod_a;
    logic [61:0]      prod_b;
    logic [36:0]      back;
    logic [31:0]      rem;
    logic [30:0]      term;
    series_t          c_next;

    always_comb
    begin
        prod_a = 63'(s_in.th2) * 63'(s_in.inner);
        prod_b = 62'(xa_reg) * 62'(SERIES_RCP[STEP]);
        back   = 37'(q0_reg) * 37'(SERIES_DIV[STEP]);
        rem    = xb_reg - back[31:0];
        term   = 31'(q0_reg) + ((rem >= 32'(SERIES_DIV[STEP])) ? 31'd1 : 31'd0);
        c_next = b_reg;
        c_next.inner = (term >= Q30_ONE) ? '0 : Q30_ONE - term;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= s_in;
            xa_reg <= prod_a[61:30];
            b_reg  <= a_reg;
            xb_reg <= xa_reg;
            q0_reg <= prod_b[61:32];
            c_reg  <= c_next;
        end
    end

    assign s_out = c_reg;

endmodule

// ===== design/usv_sine_lane.sv =====
// sine of a 32-bit turn phase as magnitude and sign, q30
module usv_sine_lane
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] phase,
    output logic [usv_pkg::MAG_W-1:0] mag,
    output logic        neg
);
    import usv_pkg::*;

    logic [30:0]      t_reg;
    logic             n0_reg, n1_reg;
    logic [TH_W-1:0]  th1_reg;
    series_t          chain [STEPS+1];
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic [30:0]      t_next;
    logic [61:0]      th_prod;
    logic [61:0]      th2_prod;
    logic [61:0]      fin_prod;
    series_t          first_next;
    series_t          first_reg;

    always_comb
    begin
        t_next = phase[30] ? Q30_ONE - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
        th_prod  = 62'(t_reg) * 62'(HALF_PI_Q30) + 62'(Q30_ONE >> 1);
        th2_prod = 62'(th1_reg) * 62'(th1_reg) + 62'(Q30_ONE >> 1);
        first_next.th    = th1_reg;
        first_next.th2   = th2_prod[61:30];
        first_next.inner = Q30_ONE;
        first_next.neg   = n1_reg;
        fin_prod = 62'(chain[STEPS].th) * 62'(chain[STEPS].inner) + 62'(Q30_ONE >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            n0_reg    <= phase[31];
            th1_reg   <= th_prod[60:30];
            n1_reg    <= n0_reg;
            first_reg <= first_next;
            mag_reg   <= fin_prod[61:30];
            neg_reg   <= chain[STEPS].neg;
        end
    end

    assign chain[0] = first_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        usv_horner_cell #(.STEP(k)) u_cell
        (
            .clk   (clk),
            .en    (en),
            .s_in  (chain[k]),
            .s_out (chain[k+1])
        );
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

// ===== design/uv_sphere_vertex_generator_core.sv =====
// Takes one grid point (row, col) per item and streams the x, y, z vertex components,
// optionally repeated as the normal and followed by u and v, with tlast on the final one.
// The datapath is a stalling chain of cells: 41 one-bit division cells, four sine lanes
// of 19 stages each and two product/rounding stages. One item enters per cycle while the
// output stage is free; the output register sends one component per cycle while m_tready
// is high, and an item has 3, 5, 6 or 8 components as set by emit_normal and emit_uv;
// that component count sets the sustained rate.
module uv_sphere_vertex_generator_core #(
    parameter int MAX_GRID  = 256,
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // row [7:0], col [15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // value [17:0], zero fill [23:18]
    output logic [2:0]  m_tuser,  // component [2:0]
    output logic        m_tlast
);
    import usv_pkg::*;

    localparam int SH_XZ = 60 - FRAC_BITS;
    localparam int SH_Y  = 30 - FRAC_BITS;
    localparam logic [63:0] RND_XZ = (64'd1 << SH_XZ) >> 1;
    localparam logic [63:0] RND_Y  = (64'd1 << SH_Y) >> 1;
    localparam logic [63:0] LIM    = 64'd1 << FRAC_BITS;
    localparam int UV_LAT = SINE_LAT + 2;

    function automatic logic [VAL_W-1:0] round_sat(input logic [63:0] m_in,
                                                   input logic [63:0] rnd,
                                                   input int sh,
                                                   input logic ng);
        logic [63:0] m;
        logic [63:0] r;
        m = (m_in + rnd) >> sh;
        if (m > LIM)
            m = LIM;
        r = ng ? (64'd0 - m) : m;
        return r[VAL_W-1:0];
    endfunction

    // configuration
    logic [DW-1:0] grid_size_reg;
    logic          emit_uv_reg, emit_normal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg   <= DW'(32);
            emit_uv_reg     <= 1'b0;
            emit_normal_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GRID_SIZE:   grid_size_reg   <= cfg_wdata;
                REG_EMIT_UV:     emit_uv_reg     <= cfg_wdata[0];
                REG_EMIT_NORMAL: emit_normal_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // divisor and clamped indices
    logic [DW-1:0]    n_eff, d, h;
    logic [ROW_W-1:0] row_c, col_c;
    logic             en;

    always_comb
    begin
        n_eff = grid_size_reg;
        if (grid_size_reg < DW'(2))
            n_eff = DW'(2);
        if (32'(grid_size_reg) > MAX_GRID)
            n_eff = DW'(MAX_GRID);
        d = n_eff - DW'(1);
        h = d >> 1;
        row_c = ({1'b0, s_tdata[7:0]} > d) ? d[ROW_W-1:0] : s_tdata[7:0];
        col_c = ({1'b0, s_tdata[15:8]} > d) ? d[ROW_W-1:0] : s_tdata[15:8];
    end

    // division chain
    rem_vec_t  rem_w  [DIV_W+1];
    word_vec_t word_w [DIV_W+1];

    always_comb
    begin
        rem_w[0] = '0;
        word_w[0][LANE_PU] = (DIV_W'(col_c) << 32) + DIV_W'(h);
        word_w[0][LANE_PV] = (DIV_W'(row_c) << 31) + DIV_W'(h);
        word_w[0][LANE_U]  = (DIV_W'(col_c) << FRAC_BITS) + DIV_W'(h);
        word_w[0][LANE_V]  = (DIV_W'(row_c) << FRAC_BITS) + DIV_W'(h);
    end

    for (genvar k = 0; k < DIV_W; k++)
    begin : g_div
        usv_div_cell u_div
        (
            .clk      (clk),
            .en       (en),
            .d        (d),
            .rem_in   (rem_w[k]),
            .word_in  (word_w[k]),
            .rem_out  (rem_w[k+1]),
            .word_out (word_w[k+1])
        );
    end

    // sine lanes
    logic [31:0]      ph_su, ph_cu, ph_sv, ph_cv;
    logic [MAG_W-1:0] m_su, m_cu, m_sv, m_cv;
    logic             n_su, n_cu, n_sv, n_cv;

    assign ph_su = word_w[DIV_W][LANE_PU][31:0];
    assign ph_cu = word_w[DIV_W][LANE_PU][31:0] + QUARTER;
    assign ph_sv = word_w[DIV_W][LANE_PV][31:0];
    assign ph_cv = word_w[DIV_W][LANE_PV][31:0] + QUARTER;

    usv_sine_lane u_su (.clk(clk), .en(en), .phase(ph_su), .mag(m_su), .neg(n_su));
    usv_sine_lane u_cu (.clk(clk), .en(en), .phase(ph_cu), .mag(m_cu), .neg(n_cu));
    usv_sine_lane u_sv (.clk(clk), .en(en), .phase(ph_sv), .mag(m_sv), .neg(n_sv));
    usv_sine_lane u_cv (.clk(clk), .en(en), .phase(ph_cv), .mag(m_cv), .neg(n_cv));

    // products and rounding
    logic [63:0]      px_reg, pz_reg;
    logic [MAG_W-1:0] my_reg;
    logic             nx_reg, ny_reg, nz_reg;
    logic [VAL_W-1:0] x_reg, y_reg, z_reg;
    logic [VAL_W-1:0] u_dly_reg [UV_LAT];
    logic [VAL_W-1:0] v_dly_reg [UV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 64'(m_cu) * 64'(m_sv);
            pz_reg <= 64'(m_su) * 64'(m_sv);
            my_reg <= m_cv;
            nx_reg <= n_cu ^ n_sv;
            nz_reg <= n_su ^ n_sv;
            ny_reg <= n_cv;
            x_reg  <= round_sat(px_reg, RND_XZ, SH_XZ, nx_reg);
            y_reg  <= round_sat(64'(my_reg), RND_Y, SH_Y, ny_reg);
            z_reg  <= round_sat(pz_reg, RND_XZ, SH_XZ, nz_reg);
            u_dly_reg[0] <= word_w[DIV_W][LANE_U][VAL_W-1:0];
            v_dly_reg[0] <= word_w[DIV_W][LANE_V][VAL_W-1:0];
            for (int k = 1; k < UV_LAT; k++)
            begin
                u_dly_reg[k] <= u_dly_reg[k-1];
                v_dly_reg[k] <= v_dly_reg[k-1];
            end
        end
    end

    // item valid chain
    logic [PIPE_LAT-1:0] valid_reg, valid_next;

    assign valid_next = {valid_reg[PIPE_LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // output serializer
    logic             out_valid_reg;
    comp_t            comp_reg, comp_next;
    logic [VAL_W-1:0] ox_reg, oy_reg, oz_reg, ou_reg, ov_reg;
    logic             last;
    logic [VAL_W-1:0] value;

    always_comb
    begin
        last = 1'b0;
        comp_next = comp_reg;
        value = ox_reg;
        case (comp_reg)
            COMP_X, COMP_NX:
            begin
                value = ox_reg;
                comp_next = (comp_reg == COMP_X) ? COMP_Y : COMP_NY;
            end
            COMP_Y, COMP_NY:
            begin
                value = oy_reg;
                comp_next = (comp_reg == COMP_Y) ? COMP_Z : COMP_NZ;
            end
            COMP_Z:
            begin
                value = oz_reg;
                last = !emit_normal_reg && !emit_uv_reg;
                comp_next = emit_normal_reg ? COMP_NX : COMP_U;
            end
            COMP_NZ:
            begin
                value = oz_reg;
                last = !emit_uv_reg;
                comp_next = COMP_U;
            end
            COMP_U:
            begin
                value = ou_reg;
                comp_next = COMP_V;
            end
            COMP_V:
            begin
                value = ov_reg;
                last = 1'b1;
            end
            default:
            begin
                value = ox_reg;
            end
        endcase
    end

    assign en = !out_valid_reg || (m_tready && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            comp_reg      <= COMP_X;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[PIPE_LAT-1];
            comp_reg      <= COMP_X;
        end
        else if (m_tready)
        begin
            comp_reg <= comp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= x_reg;
            oy_reg <= y_reg;
            oz_reg <= z_reg;
            ou_reg <= u_dly_reg[UV_LAT-1];
            ov_reg <= v_dly_reg[UV_LAT-1];
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(value);
    assign m_tuser  = comp_reg;
    assign m_tlast  = last;

    a_last_matches_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser == COMP_V) ||
            (m_tuser == COMP_NZ && !emit_uv_reg) ||
            (m_tuser == COMP_Z && !emit_uv_reg && !emit_normal_reg))
        else $error("tlast on wrong component");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || (m_tready && m_tlast))
        else $error("input taken while output item unfinished");

    a_item_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("item cut short");

endmodule
